// ===== hdl/act_pkg.sv =====
package act_pkg;

  typedef enum logic [1:0] {
    ACT_LOOKUP   = 2'd0,
    ACT_INS_RES  = 2'd1,
    ACT_INS_WAIT = 2'd2,
    ACT_TICK     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_LOOKUP = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_RESEND = 3'd2,
    KIND_FREED  = 3'd3,
    KIND_TICK   = 3'd4
  } kind_t;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_DONE,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic start;
    logic step;
    logic apply;
    logic age;
    logic load_out;
    logic [2:0] out_kind;
    logic out_ok;
    logic out_slot;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic act_tick;
  } sts_t;

endpackage

// ===== hdl/act_ctrl.sv =====
module act_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          out_busy,
  input  act_pkg::sts_t sts,
  output act_pkg::cmd_t cmd,
  output logic          idle
);
  import act_pkg::*;

  fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    idle         = 1'b0;
    unique case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.act_tick) begin
          if (sts.hit) begin
            state_next = S_EMIT;
          end else begin
            cmd.age = 1'b1;
            if (sts.scan_end) begin
              state_next = S_DONE;
            end else begin
              cmd.step = 1'b1;
            end
          end
        end else if (sts.hit || sts.scan_end) begin
          state_next = S_OUT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          cmd.out_slot = 1'b1;
          cmd.apply    = 1'b1;
          if (sts.scan_end) begin
            state_next = S_DONE;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_TICK;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          cmd.apply    = 1'b1;
          cmd.out_ok   = sts.hit;
          cmd.out_slot = sts.hit;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/act_dp.sv =====
module act_dp #(
  parameter int ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  act_pkg::cmd_t cmd,
  input  logic [117:0]  in_data,
  input  logic          cfg_fire,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          out_take,
  output act_pkg::sts_t sts,
  output logic          out_valid,
  output logic [109:0]  out_data,
  output logic          out_last
);
  import act_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [15:0] timeout_ticks;
  logic [3:0]  retry_limit;

  logic [1:0]  slot_state [ENTRIES];
  logic [17:0] slot_ttl [ENTRIES];
  logic [4:0]  slot_retries [ENTRIES];
  logic [15:0] slot_protocol [ENTRIES];
  logic [31:0] slot_ip [ENTRIES];
  logic [47:0] slot_hw [ENTRIES];
  logic [3:0]  slot_port [ENTRIES];
  logic [IW-1:0] alloc_pointer;

  logic [1:0]  act;
  logic [15:0] r_pro, r_elapsed;
  logic [31:0] r_ip;
  logic [47:0] r_hw;
  logic [3:0]  r_port;
  logic [IW-1:0] idx, cnt;

  logic [17:0] ttl_sub;
  logic        live, hit;

  assign live    = slot_state[idx] != ST_FREE;
  assign ttl_sub = (slot_ttl[idx] > {2'b0, r_elapsed}) ?
                   slot_ttl[idx] - {2'b0, r_elapsed} : 18'd0;

  always_comb begin
    unique case (act)
      ACT_LOOKUP: hit = live && slot_protocol[idx] == r_pro && slot_ip[idx] == r_ip;
      ACT_TICK:   hit = live && ttl_sub == 18'd0;
      default:    hit = !live;
    endcase
  end

  assign sts.hit      = hit;
  assign sts.scan_end = cnt == IW'(ENTRIES - 1);
  assign sts.act_tick = act == ACT_TICK;

  logic resend;
  assign resend = slot_state[idx] == ST_WAIT && slot_retries[idx] != 5'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 16'd600;
      retry_limit   <= 4'd4;
      alloc_pointer <= '0;
      out_valid     <= 1'b0;
      act           <= ACT_LOOKUP;
      idx           <= '0;
      cnt           <= '0;
      for (int i = 0; i < ENTRIES; i++) slot_state[i] <= ST_FREE;
    end else begin
      if (cfg_fire) begin
        if (cfg_index == CFG_TIMEOUT) timeout_ticks <= cfg_data;
        else retry_limit <= cfg_data[3:0];
      end
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
      if (cmd.start) begin
        act       <= in_data[1:0];
        r_pro     <= in_data[17:2];
        r_ip      <= in_data[49:18];
        r_hw      <= in_data[97:50];
        r_port    <= in_data[101:98];
        r_elapsed <= in_data[117:102];
        cnt       <= '0;
        idx       <= (in_data[1:0] == ACT_INS_RES || in_data[1:0] == ACT_INS_WAIT) ?
                     alloc_pointer : '0;
      end
      if (cmd.age && live) begin
        slot_ttl[idx] <= ttl_sub;
      end
      if (cmd.step) begin
        cnt <= cnt + IW'(1);
        idx <= (idx == IW'(ENTRIES - 1)) ? '0 : idx + IW'(1);
      end
      if (cmd.load_out) begin
        out_last  <= cmd.out_last;
        if (cmd.out_kind == KIND_TICK) begin
          out_data <= {107'd0, KIND_TICK};
        end else if (!cmd.out_slot) begin
          out_data <= {106'd0, cmd.out_ok,
                       (act == ACT_LOOKUP) ? KIND_LOOKUP : KIND_INSERT};
        end else if (act == ACT_TICK) begin
          out_data <= {slot_port[idx], slot_hw[idx], slot_ip[idx], slot_protocol[idx],
                       slot_state[idx], 4'(idx), 1'b0,
                       resend ? KIND_RESEND : KIND_FREED};
        end else if (act == ACT_LOOKUP) begin
          out_data <= {slot_port[idx], slot_hw[idx], slot_ip[idx], slot_protocol[idx],
                       slot_state[idx], 4'(idx), cmd.out_ok, KIND_LOOKUP};
        end else begin
          out_data <= {r_port, (act == ACT_INS_RES) ? r_hw : 48'd0, r_ip, r_pro,
                       (act == ACT_INS_RES) ? ST_RES : ST_WAIT, 4'(idx), cmd.out_ok,
                       KIND_INSERT};
        end
      end
      if (cmd.apply && cmd.out_slot) begin
        if (act == ACT_TICK) begin
          if (resend) begin
            slot_retries[idx] <= slot_retries[idx] - 5'd1;
            slot_ttl[idx]     <= {2'b0, timeout_ticks};
          end else begin
            slot_state[idx] <= ST_FREE;
          end
        end else if (act != ACT_LOOKUP) begin
          slot_state[idx]    <= (act == ACT_INS_RES) ? ST_RES : ST_WAIT;
          slot_ttl[idx]      <= {2'b0, timeout_ticks};
          slot_retries[idx]  <= {1'b0, retry_limit};
          slot_protocol[idx] <= r_pro;
          slot_ip[idx]       <= r_ip;
          slot_hw[idx]       <= (act == ACT_INS_RES) ? r_hw : 48'd0;
          slot_port[idx]     <= r_port;
          alloc_pointer      <= (idx == IW'(ENTRIES - 1)) ? '0 : idx + IW'(1);
        end
      end
    end
  end

endmodule

// ===== hdl/arp_cache_table_top.sv =====
// ARP cache table: a table of ENTRIES address-resolution slots.
// Requests enter on the s_axis channel; tdata carries action, protocol,
// ip_addr, hw_addr, dev_port and elapsed. Results leave on m_axis, with
// tdata holding kind, ok, entry_index, entry_state and the entry contents,
// and tlast marking the final result of a request.
// Configuration writes arrive on the cfg channel: index 0 is timeout_ticks,
// index 1 is retry_limit; other indexes are ignored.
// A lookup walks the slots one per cycle from slot 0 and stops at the first
// match; an insert walks them from the allocation pointer and stops at the
// first free slot. A tick visits every slot in turn, one a cycle, but pauses
// at each slot that emits an event, longer while the result register is busy;
// the tick-done result comes last.
// One request is handled at a time; s_axis_tready is high only when idle.
// If the receiver stalls, the table walk holds until the result register
// is free; no result is lost. Reset frees every slot, zeroes the allocation
// pointer and loads the register defaults.
module arp_cache_table_top #(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action, protocol, ip_addr, hw_addr, dev_port, elapsed (lowest first)
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kind, ok, entry_index, entry_state, entry_protocol, entry_ip, entry_hw,
  // entry_port (lowest first)
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import act_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle, in_fire, out_busy;
  logic [109:0] od;

  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && idle;
  assign cfg_ready     = 1'b1;
  assign out_busy      = m_axis_tvalid && !m_axis_tready;
  assign m_axis_tdata  = {2'b0, od};

  act_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_busy),
    .sts(sts), .cmd(cmd), .idle(idle)
  );

  act_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_data(s_axis_tdata[117:0]),
    .cfg_fire(cfg_valid && cfg_index[1] == 1'b0), .cfg_index(cfg_index[0]),
    .cfg_data(cfg_data), .out_take(m_axis_tvalid && m_axis_tready),
    .sts(sts), .out_valid(m_axis_tvalid), .out_data(od), .out_last(m_axis_tlast)
  );

endmodule

// ===== verif/arp_cache_table_top_tb.sv =====
`timescale 1ns / 1ps

module arp_cache_table_top_tb;
  import act_pkg::*;

  localparam int NSLOT = 16;

  typedef struct {
    action_t     act;
    logic [15:0] proto;
    logic [31:0] ip;
    logic [47:0] hw;
    logic [3:0]  port;
    logic [15:0] elapsed;
  } req_t;

  typedef struct {
    kind_t       kind;
    logic        ok;
    logic [3:0]  idx;
    logic [1:0]  st;
    logic [15:0] proto;
    logic [31:0] ip;
    logic [47:0] hw;
    logic [3:0]  port;
    logic        last;
  } entry_res_t;

  class arp_scoreboard;
    entry_res_t  pending_q[$];
    int          errors;
    int          kind_seen[5];
    logic [15:0] timeout_ticks;
    logic [3:0]  retry_limit;
    logic [1:0]  s_state[NSLOT];
    int          s_ttl[NSLOT];
    int          s_retries[NSLOT];
    logic [15:0] s_proto[NSLOT];
    logic [31:0] s_ip[NSLOT];
    logic [47:0] s_hw[NSLOT];
    logic [3:0]  s_port[NSLOT];
    int          alloc_ptr;

    function new();
      timeout_ticks = 16'd600;
      retry_limit = 4'd4;
      alloc_ptr = 0;
      errors = 0;
      for (int i = 0; i < NSLOT; i++) begin
        s_state[i] = ST_FREE;
        s_ttl[i] = 0;
        s_retries[i] = 0;
        s_proto[i] = '0;
        s_ip[i] = '0;
        s_hw[i] = '0;
        s_port[i] = '0;
      end
      for (int k = 0; k < 5; k++) kind_seen[k] = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [15:0] value);
      if (index == 2'(CFG_TIMEOUT)) timeout_ticks = value;
      else if (index == 2'(CFG_RETRY)) retry_limit = value[3:0];
    endfunction

    function void push_result(kind_t kind, logic ok, int slot, bit with_slot, logic last);
      entry_res_t r;
      r = '{kind: kind, ok: ok, idx: '0, st: '0, proto: '0, ip: '0, hw: '0,
            port: '0, last: last};
      if (with_slot) begin
        r.idx = slot[3:0];
        r.st = s_state[slot];
        r.proto = s_proto[slot];
        r.ip = s_ip[slot];
        r.hw = s_hw[slot];
        r.port = s_port[slot];
      end
      pending_q.push_back(r);
    endfunction

    function void note_request(req_t q);
      int p;
      int found;
      found = -1;
      case (q.act)
        ACT_LOOKUP: begin
          for (int i = 0; i < NSLOT && found < 0; i++)
            if (s_state[i] != ST_FREE && s_proto[i] == q.proto && s_ip[i] == q.ip) found = i;
          if (found >= 0) push_result(KIND_LOOKUP, 1'b1, found, 1, 1'b1);
          else push_result(KIND_LOOKUP, 1'b0, 0, 0, 1'b1);
        end
        ACT_INS_RES, ACT_INS_WAIT: begin
          p = alloc_ptr;
          for (int i = 0; i < NSLOT && found < 0; i++) begin
            if (s_state[p] == ST_FREE) found = p;
            p = (p + 1) % NSLOT;
          end
          if (found < 0) begin
            push_result(KIND_INSERT, 1'b0, 0, 0, 1'b1);
          end else begin
            s_state[found] = (q.act == ACT_INS_RES) ? ST_RES : ST_WAIT;
            s_ttl[found] = timeout_ticks;
            s_retries[found] = retry_limit;
            s_proto[found] = q.proto;
            s_ip[found] = q.ip;
            s_hw[found] = (q.act == ACT_INS_RES) ? q.hw : '0;
            s_port[found] = q.port;
            alloc_ptr = (found + 1) % NSLOT;
            push_result(KIND_INSERT, 1'b1, found, 1, 1'b1);
          end
        end
        default: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (s_state[i] != ST_FREE) begin
              s_ttl[i] = (s_ttl[i] > q.elapsed) ? s_ttl[i] - q.elapsed : 0;
              if (s_ttl[i] == 0) begin
                if (s_state[i] == ST_WAIT && s_retries[i] != 0) begin
                  s_retries[i]--;
                  s_ttl[i] = timeout_ticks;
                  push_result(KIND_RESEND, 1'b0, i, 1, 1'b0);
                end else begin
                  push_result(KIND_FREED, 1'b0, i, 1, 1'b0);
                  s_state[i] = ST_FREE;
                end
              end
            end
          end
          push_result(KIND_TICK, 1'b0, 0, 0, 1'b1);
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_result(logic [111:0] d, logic last);
      entry_res_t g;
      entry_res_t e;
      g.kind = kind_t'(d[2:0]);
      g.ok = d[3];
      g.idx = d[7:4];
      g.st = d[9:8];
      g.proto = d[25:10];
      g.ip = d[57:26];
      g.hw = d[105:58];
      g.port = d[109:106];
      g.last = last;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d", d[2:0]));
      end else begin
        e = pending_q.pop_front();
        if (d[2:0] < 5) kind_seen[d[2:0]]++;
        if (g.kind !== e.kind || g.ok !== e.ok || g.idx !== e.idx || g.st !== e.st ||
            g.proto !== e.proto || g.ip !== e.ip || g.hw !== e.hw ||
            g.port !== e.port || g.last !== e.last)
          report($sformatf(
            "got k%0d ok%0d i%0d s%0d %h %h %h p%0d l%0d exp k%0d ok%0d i%0d s%0d %h %h %h p%0d l%0d",
            g.kind, g.ok, g.idx, g.st, g.proto, g.ip, g.hw, g.port, g.last,
            e.kind, e.ok, e.idx, e.st, e.proto, e.ip, e.hw, e.port, e.last));
      end
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  arp_cache_table_top #(.ENTRIES(NSLOT)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  arp_scoreboard sb;
  bit            quiet;
  bit            held_off;
  int            sent;
  logic [31:0]   ip_pool[8];
  logic [15:0]   proto_pool[4];

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", sb.pending_q.size());
    $display("== FAIL ==");
    $finish;
  end

  task send_req(req_t q);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {2'b00, q.elapsed, q.port, q.hw, q.ip, q.proto, q.act};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(q);
    sent++;
  endtask

  task write_cfg(logic [1:0] index, logic [15:0] value);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function req_t mk(action_t a, logic [15:0] pr, logic [31:0] ip, logic [47:0] hw,
                    logic [3:0] port, logic [15:0] el);
    req_t q;
    q = '{act: a, proto: pr, ip: ip, hw: hw, port: port, elapsed: el};
    return q;
  endfunction

  function req_t rand_req(logic [15:0] tmo);
    req_t q;
    int   w;
    w = $urandom_range(0, 99);
    q.act = (w < 30) ? ACT_LOOKUP : (w < 58) ? ACT_INS_RES : (w < 78) ? ACT_INS_WAIT : ACT_TICK;
    if ($urandom_range(0, 9) == 0) begin
      q.proto = 16'($urandom);
      q.ip = $urandom;
    end else begin
      q.proto = proto_pool[$urandom_range(0, 3)];
      q.ip = ip_pool[$urandom_range(0, 7)];
    end
    q.hw = 48'({$urandom, $urandom});
    q.port = 4'($urandom);
    if ($urandom_range(0, 4) == 0) q.elapsed = 16'($urandom);
    else q.elapsed = 16'($urandom_range(0, (tmo < 2) ? 2 : tmo / 2));
    return q;
  endfunction

  task run_phase(logic [15:0] tmo, logic [3:0] rl, int count);
    wait_idle();
    write_cfg(2'(CFG_TIMEOUT), tmo);
    write_cfg(2'(CFG_RETRY), {12'($urandom), rl});
    for (int n = 0; n < count; n++) begin
      if (sent > 330) quiet = 1'b1;
      send_req(rand_req(tmo));
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    held_off = 1'b0;
    sent = 0;
    for (int i = 0; i < 8; i++) ip_pool[i] = $urandom;
    proto_pool = '{16'h0800, 16'h86DD, 16'h0000, 16'hFFFF};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_req(mk(ACT_LOOKUP, '0, '0, '0, '0, '0));
    send_req(mk(ACT_INS_RES, '1, '1, '1, '1, '0));
    send_req(mk(ACT_INS_WAIT, '0, '0, '1, '0, '1));
    send_req(mk(ACT_LOOKUP, '1, '1, '0, '0, '0));
    send_req(mk(ACT_LOOKUP, '0, '0, '0, '0, '0));
    send_req(mk(ACT_INS_RES, '1, '1, 48'h1234_5678_9ABC, 4'd7, '0));
    send_req(mk(ACT_LOOKUP, '1, '1, '0, '0, '0));
    send_req(mk(ACT_TICK, '0, '0, '0, '0, 16'd0));
    send_req(mk(ACT_TICK, '0, '0, '0, '0, 16'hFFFF));
    for (int i = 0; i < 16; i++)
      send_req(mk(ACT_INS_RES, 16'h0800, 32'h0A00_0000 + i, 48'({$urandom, $urandom}),
                  4'(i), '0));
    send_req(mk(ACT_TICK, '0, '0, '0, '0, 16'hFFFF));

    wait_idle();
    write_cfg(2'(CFG_TIMEOUT), 16'd0);
    write_cfg(2'(CFG_RETRY), 16'd0);
    write_cfg(2'd2, 16'hFFFF);
    write_cfg(2'd3, 16'h0001);
    send_req(mk(ACT_TICK, '0, '0, '0, '0, 16'hFFFF));
    send_req(mk(ACT_INS_WAIT, 16'h0806, 32'hC0A8_0001, '0, 4'd3, '0));
    send_req(mk(ACT_INS_RES, 16'h0806, 32'hC0A8_0002, '1, 4'd4, '0));
    send_req(mk(ACT_TICK, '0, '0, '0, '0, 16'd0));

    run_phase(16'd20, 4'd2, 90);
    run_phase(16'd1, 4'd0, 70);
    run_phase(16'hFFFF, 4'd15, 90);
    run_phase(16'd300, 4'd4, 70);

    wait_idle();
    if (sb.pending_q.size() != 0) sb.report("results left outstanding");
    $display("Sent %0d requests over five register settings, with zero and full timeouts,",
             sent);
    $display("no retries and the most retries; results: %0d lookup, %0d insert, %0d resend, %0d freed, %0d tick.",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
             sb.kind_seen[4]);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int gap;
    @(negedge clk);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      @(negedge clk);
      if (!held_off && sent > 40) begin
        held_off = 1'b1;
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        gap = $urandom_range(1, 9);
        repeat (gap) @(negedge clk);
      end
      m_axis_tready = 1'b1;
    end
  end

endmodule
